// ===== hw/rtl/fdg_pkg.sv =====
package fdg_pkg;

    // Frame geometry and the depth of the stored previous frame.
    localparam int FRAME_WIDTH  = 932;
    localparam int FRAME_HEIGHT = 576;
    localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    // Pixel layout: blue, green, red, alpha from the least significant byte up.
    localparam int PIXEL_W   = 32;
    localparam int CHANNEL_W = 8;

    // Register map: byte address 4*i selects register i.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic {
        REG_DIFF_MODE = 1'b0,
        REG_UNUSED    = 1'b1
    } t_reg_index;

    typedef logic [STORE_AW-1:0] t_store_addr;
    typedef logic [PIXEL_W-1:0]  t_pixel;

    // Status that travels with the stored pixel read back for one item.
    typedef struct packed {
        logic first_frame;
        logic frame_last;
    } t_store_status;

endpackage

// ===== hw/rtl/fdg_frame_store.sv =====
module fdg_frame_store
    import fdg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  t_pixel        i_pixel,
    output t_pixel        o_rd_data,
    output t_store_status o_status
);

    localparam t_store_addr LastAddr = t_store_addr'(STORE_DEPTH - 1);

    logic [PIXEL_W-1:0] mem [STORE_DEPTH];

    t_store_addr   r_addr;
    t_store_addr   n_addr;
    logic          r_filled;
    logic          n_filled;
    t_pixel        r_rd_data;
    t_store_status r_status;

    // The raster address follows the row and column of the frame and wraps
    // after the last pixel of the frame.
    always_comb begin
        n_addr   = r_addr;
        n_filled = r_filled;
        if (i_wr) begin
            if (r_addr == LastAddr) begin
                n_addr   = '0;
                n_filled = 1'b1;
            end else begin
                n_addr = r_addr + t_store_addr'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_filled <= 1'b0;
        end else begin
            r_addr   <= n_addr;
            r_filled <= n_filled;
        end
    end

    // Read the old pixel and store the new one at the same address. Until a
    // whole frame has been stored, every entry read is one never written,
    // so the first-frame flag stands in for a cleared memory.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[r_addr]          <= i_pixel;
            r_rd_data            <= mem[r_addr];
            r_status.first_frame <= !r_filled;
            r_status.frame_last  <= (r_addr == LastAddr);
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_status  = r_status;

endmodule

// ===== hw/rtl/fdg_pixel_diff.sv =====
module fdg_pixel_diff
    import fdg_pkg::*;
(
    input  t_pixel i_pixel,
    input  t_pixel i_prev,
    input  logic   i_first_frame,
    input  logic   i_diff_mode,
    output t_pixel o_pixel
);

    localparam logic [CHANNEL_W-1:0] GrayMax = '1;

    t_pixel               prev;
    logic [CHANNEL_W-1:0] diff [3];
    logic [CHANNEL_W+1:0] sum;
    logic [CHANNEL_W-1:0] gray;

    // Before a full frame has been stored the previous pixel reads as zero.
    assign prev = i_first_frame ? '0 : i_prev;

    // Absolute difference of blue, green and red; alpha takes no part.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (i_pixel[c*CHANNEL_W +: CHANNEL_W] >= prev[c*CHANNEL_W +: CHANNEL_W]) begin
                diff[c] = i_pixel[c*CHANNEL_W +: CHANNEL_W] - prev[c*CHANNEL_W +: CHANNEL_W];
            end else begin
                diff[c] = prev[c*CHANNEL_W +: CHANNEL_W] - i_pixel[c*CHANNEL_W +: CHANNEL_W];
            end
        end
    end

    // Sum the three channels and saturate at full white.
    always_comb begin
        sum  = {2'b00, diff[0]} + {2'b00, diff[1]} + {2'b00, diff[2]};
        gray = (sum > {2'b00, GrayMax}) ? GrayMax : sum[CHANNEL_W-1:0];
    end

    // Difference mode gives opaque gray; passthrough gives the pixel as is.
    assign o_pixel = i_diff_mode ? {GrayMax, gray, gray, gray} : i_pixel;

endmodule

// ===== hw/rtl/frame_difference_gray.sv =====
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_pixel_in
// output    o_out_valid / i_out_ready   o_pixel_out, o_frame_last
// config    psel, penable, pwrite       paddr, pwdata, prdata (pready held high)
//
// One item per clock: an item is accepted every cycle that the output side takes
// results. The accepting edge registers the item and the stored pixel read from the
// frame store; the output register loads the result once it is free, and the result
// is offered from the output register.
// Reset clears the raster address and the pipeline valid flags and sets the mode back to
// difference mode; the stored frame reads as zero until one whole frame has passed.
// A stalled output holds its result while one further item waits in the read stage.
module frame_difference_gray
    import fdg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_pixel_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_pixel_out,
    output logic               o_frame_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic          in_accept;
    logic          s1_advance;
    logic          cfg_write;
    t_reg_index    reg_index;
    t_pixel        rd_data;
    t_store_status status;
    t_pixel        result;

    logic          r_diff_mode;
    logic          r_s1_valid;
    t_pixel        r_s1_pixel;
    logic          r_s1_mode;
    logic          r_out_valid;
    t_pixel        r_out_pixel;
    logic          r_out_last;

    // Configuration register write and read-back.
    assign pready    = 1'b1;
    assign reg_index = t_reg_index'(paddr[PADDR_W-1]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_mode <= 1'b1;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_DIFF_MODE: r_diff_mode <= pwdata[0];
                default:       r_diff_mode <= r_diff_mode;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_DIFF_MODE: prdata = {{(PDATA_W-1){1'b0}}, r_diff_mode};
            default:       prdata = '0;
        endcase
    end

    // Flow control: the read stage moves on when the output register is free.
    assign s1_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign in_accept   = i_in_valid && o_in_ready;

    fdg_frame_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (in_accept),
        .i_pixel   (i_pixel_in),
        .o_rd_data (rd_data),
        .o_status  (status)
    );

    // Read stage: the item is held here beside the stored pixel read for it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pixel <= i_pixel_in;
            r_s1_mode  <= r_diff_mode;
        end
    end

    fdg_pixel_diff u_diff (
        .i_pixel       (r_s1_pixel),
        .i_prev        (rd_data),
        .i_first_frame (status.first_frame),
        .i_diff_mode   (r_s1_mode),
        .o_pixel       (result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_pixel <= result;
            r_out_last  <= status.frame_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pixel;
    assign o_frame_last = r_out_last;

endmodule

// ===== test/tb_frame_difference_gray.sv =====
`timescale 1ns / 1ps

module tb_frame_difference_gray;
    import fdg_pkg::*;

    localparam bit          MODE_DIFF   = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned REPORT_CAP  = 40;

    // Corner pixels for difference mode against the zeroed first frame.
    localparam bit [31:0] DIFF_CORNERS [12] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h0055_5555,
        32'h0055_5556, 32'h0055_5554, 32'h0000_00FF, 32'h00FF_0000,
        32'h0000_FF00, 32'h0001_0101, 32'h8080_8080, 32'h7F7F_7F7F
    };

    // Corner pixels for passthrough mode.
    localparam bit [31:0] PASS_CORNERS [5] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'hA5A5_A5A5
    };

    typedef struct packed {
        t_pixel pixel;
        logic   last;
    } t_gray_result;

    // Shadow of the block: its own copy of the previous frame, raster position and
    // mode, and the queue of results still owed by the block.
    class diff_scoreboard;
        bit [PIXEL_W-1:0] frame_copy [STORE_DEPTH];
        int unsigned      col;
        int unsigned      row;
        bit               diff_on;
        t_gray_result     expected_pixels [$];

        function new();
            col     = 0;
            row     = 0;
            diff_on = MODE_DIFF;
        endfunction

        function int unsigned position();
            return row * FRAME_WIDTH + col;
        endfunction

        function t_pixel stored_here();
            return frame_copy[position()];
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        function void note_register(input t_reg_index idx, input logic [PDATA_W-1:0] value);
            if (idx == REG_DIFF_MODE) begin
                diff_on = value[0];
            end
        endfunction

        // Work out the result of one accepted item and move the raster on.
        function void note_pixel(input t_pixel px);
            t_pixel       prior;
            int unsigned  sum;
            int unsigned  a;
            int unsigned  b;
            bit [7:0]     gray;
            t_gray_result r;
            prior = frame_copy[position()];
            sum   = 0;
            for (int c = 0; c < 3; c++) begin
                a   = px[8*c +: 8];
                b   = prior[8*c +: 8];
                sum = sum + ((a >= b) ? (a - b) : (b - a));
            end
            gray    = (sum > 255) ? 8'hFF : 8'(sum);
            r.pixel = diff_on ? {8'hFF, gray, gray, gray} : px;
            r.last  = (col == FRAME_WIDTH - 1) && (row == FRAME_HEIGHT - 1);
            expected_pixels.push_back(r);
            frame_copy[position()] = px;
            if (col == FRAME_WIDTH - 1) begin
                col = 0;
                row = (row == FRAME_HEIGHT - 1) ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        // Compare one result with the oldest expectation, field by field.
        function bit check_output(input t_pixel px, input logic last, output string msg);
            t_gray_result want;
            msg = "";
            if (expected_pixels.size() == 0) begin
                msg = $sformatf("result %h arrived with no item pending", px);
                return 1'b0;
            end
            want = expected_pixels.pop_front();
            if (px !== want.pixel) begin
                msg = $sformatf("pixel_out %h, wanted %h", px, want.pixel);
            end
            if (last !== want.last) begin
                msg = {msg, $sformatf(" frame_last %b, wanted %b", last, want.last)};
            end
            return (msg == "");
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [31:0]        i_pixel_in  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic [31:0]        o_pixel_out;
    logic               o_frame_last;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    diff_scoreboard sb;
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count    = 0;
    int unsigned    sink_hold      = 0;
    bit             sender_idling  = 1'b0;
    bit             sink_stalling  = 1'b0;
    string          mismatch_note;

    frame_difference_gray uut (.*);

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Pixels are either fully random, saturated per channel, or close to the
    // stored pixel so that the difference sums spread over the whole range.
    function automatic t_pixel random_pixel();
        t_pixel      base;
        t_pixel      px;
        int unsigned pick;
        int          level;
        base = sb.stored_here();
        pick = $urandom_range(0, 9);
        px   = $urandom;
        if (pick < 3) return px;
        for (int c = 0; c < 3; c++) begin
            if (pick < 5) begin
                px[8*c +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end else if ($urandom_range(0, 3) == 0) begin
                px[8*c +: 8] = base[8*c +: 8];
            end else begin
                level = int'(base[8*c +: 8]) + int'($urandom_range(0, 96)) - 48;
                if (level < 0) level = 0;
                if (level > 255) level = 255;
                px[8*c +: 8] = 8'(level);
            end
        end
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Offer one item, with an optional gap before it, and wait for acceptance.
    task automatic send_pixel(input t_pixel px);
        int unsigned gap;
        gap = sender_idling ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(px);
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Setup and access phases, then the bus returns to idle.
    task automatic write_register(input t_reg_index idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.note_register(idx, value);
        @(posedge i_clk);
    endtask

    // One stretch of random items under a freshly written mode.
    task automatic run_segment(input int unsigned count, input bit mode, input bit idling);
        logic [PDATA_W-1:0] data;
        wait_drained();
        data    = $urandom;
        data[0] = mode;
        write_register(REG_DIFF_MODE, data);
        sender_idling = idling;
        sink_stalling = idling;
        repeat (count) begin
            send_pixel(random_pixel());
            if ($urandom_range(0, 149) == 0) wait_drained();
        end
    endtask

    // Result side: ready stays high, or while stalling is held high or low for random stretches.
    always @(posedge i_clk) begin
        if (!sink_stalling) begin
            i_out_ready <= 1'b1;
            sink_hold   <= 0;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
            sink_hold   <= pick_gap();
        end
    end

    // Every accepted result is checked against the shadow.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (!sb.check_output(o_pixel_out, o_frame_last, mismatch_note)) begin
                report_mismatch(mismatch_note);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up if the run hangs.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_frame_difference_gray failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Difference mode straight out of reset, against the zeroed frame.
        foreach (DIFF_CORNERS[k]) send_pixel(DIFF_CORNERS[k]);

        // Passthrough corners.
        wait_drained();
        write_register(REG_DIFF_MODE, '0);
        foreach (PASS_CORNERS[k]) send_pixel(PASS_CORNERS[k]);

        // A write to the unused register must leave passthrough in force.
        wait_drained();
        write_register(REG_UNUSED, '1);
        send_pixel(32'h5A5A_5A5A);
        send_pixel(32'h0F0F_0F0F);

        // Back to difference mode with every data bit set.
        wait_drained();
        write_register(REG_DIFF_MODE, '1);
        send_pixel(32'h0102_0304);
        send_pixel(32'h00FE_00FE);
        send_pixel(32'hFF00_FF01);

        // Random items across a row boundary, modes alternating.
        for (int s = 0; s < 12; s++) begin
            run_segment(94, (s % 2 == 0), (s != 4));
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_frame_difference_gray passed");
        end else begin
            $display("tb_frame_difference_gray failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fdg_pkg.sv
hw/rtl/fdg_frame_store.sv
hw/rtl/fdg_pixel_diff.sv
hw/rtl/frame_difference_gray.sv
test/tb_frame_difference_gray.sv
